@@ sv/two_way_lru_cache_tag_lookup_macros.svh @@
`ifndef TWO_WAY_LRU_CACHE_TAG_LOOKUP_MACROS_SVH
`define TWO_WAY_LRU_CACHE_TAG_LOOKUP_MACROS_SVH

// check in the same cycle
`define LTL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check in the following cycle
`define LTL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/lru_tag_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lru_tag_pkg;

    localparam int IN_TDATA_W  = 32;
    localparam int OFF_OUT_W   = 5;
    localparam int BLK_OUT_W   = 27;
    localparam int SET_OUT_W   = 6;
    localparam int TAG_OUT_W   = 21;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [0:0] {
        S_READ,
        S_EVAL
    } t_back_state;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic [TAG_OUT_W-1:0] evicted_tag;
        logic                 replaced_valid;
        logic                 is_miss;
        logic [TAG_OUT_W-1:0] tag_value;
        logic                 way_used;
        logic [SET_OUT_W-1:0] set_index;
        logic [BLK_OUT_W-1:0] block_number;
        logic [OFF_OUT_W-1:0] byte_offset;
    } t_result;

    localparam int RESULT_W    = $bits(t_result);
    localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

`default_nettype wire

@@ sv/two_way_lru_cache_tag_lookup.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  tdata bits  Fields (lowest bit up)
// s_axis    in   32          address
// m_axis    out  88          byte_offset, block_number, set_index, way_used, tag_value,
//                            is_miss, replaced_valid, evicted_tag, zero pad
//
// Lookup stage: S_READ does the registered tag RAM read, S_EVAL the compare, way choice
// and update, then the next item is read. Items reach it via the input register and queue.
// Reset clears valid and LRU flops at once; no clearing pass, tag RAMs stay unreset.
// A two-entry queue decouples intake from lookup; m_axis stalls hold the result
// register while intake keeps filling the queue.

module two_way_lru_cache_tag_lookup #(
    parameter int NUM_SETS   = 64,
    parameter int LINE_BYTES = 32,
    parameter int ADDR_BITS  = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [lru_tag_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // address
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // byte_offset, block_number, set_index, way_used, tag_value, is_miss,
    // replaced_valid, evicted_tag, zero pad
    output logic [lru_tag_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import lru_tag_pkg::*;

    localparam int EFF_ADDR_W = (ADDR_BITS < IN_TDATA_W) ? ADDR_BITS : IN_TDATA_W;
    localparam int OFF_W      = $clog2(LINE_BYTES);
    localparam int SET_W      = $clog2(NUM_SETS);
    localparam int TAG_RAW_W  = EFF_ADDR_W - OFF_W - SET_W;
    localparam int TAG_W      = (TAG_RAW_W < 1) ? 1 : TAG_RAW_W;
    localparam int REQ_W      = TAG_W + SET_W + OFF_W;

    t_q_stat          w_q_stat;
    logic             w_push;
    logic [REQ_W-1:0] w_push_req;
    logic             w_pop;
    logic [REQ_W-1:0] w_q_data;
    t_result          w_result;

    lru_tag_front #(
        .ADDR_W (EFF_ADDR_W),
        .REQ_W  (REQ_W)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_address (s_axis_tdata),
        .i_q_stat  (w_q_stat),
        .o_push    (w_push),
        .o_req     (w_push_req)
    );

    lru_tag_queue #(
        .WIDTH (REQ_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_req),
        .i_pop   (w_pop),
        .o_data  (w_q_data),
        .o_stat  (w_q_stat)
    );

    lru_tag_back #(
        .NUM_SETS (NUM_SETS),
        .OFF_W    (OFF_W),
        .SET_W    (SET_W),
        .TAG_W    (TAG_W),
        .REQ_W    (REQ_W)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (w_q_stat),
        .i_q_data (w_q_data),
        .o_pop    (w_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (w_result)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - RESULT_W){1'b0}}, w_result};

endmodule

`default_nettype wire

@@ sv/lru_tag_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lru_tag_queue #(
    parameter int WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [WIDTH-1:0]     i_data,
    input  logic                 i_pop,
    output logic [WIDTH-1:0]     o_data,
    output lru_tag_pkg::t_q_stat o_stat
);
    import lru_tag_pkg::*;

    logic [WIDTH-1:0]       r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic [QUEUE_CNT_W-1:0] n_count;

    always_comb begin
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + QUEUE_CNT_W'(1);
            2'b01:   n_count = r_count - QUEUE_CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

`default_nettype wire

@@ sv/lru_tag_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lru_tag_front #(
    parameter int ADDR_W = 32,
    parameter int REQ_W  = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [lru_tag_pkg::IN_TDATA_W-1:0]  i_address,
    input  lru_tag_pkg::t_q_stat                i_q_stat,
    output logic                                o_push,
    output logic [REQ_W-1:0]                    o_req
);
    import lru_tag_pkg::*;

    logic             r_valid;
    logic [REQ_W-1:0] r_req;
    logic [REQ_W-1:0] n_req;
    logic             w_accept;

    // split into {tag, set, offset}; bits above the address width drop
    always_comb begin
        n_req             = '0;
        n_req[ADDR_W-1:0] = i_address[ADDR_W-1:0];
    end

    assign o_push   = r_valid && !i_q_stat.full;
    assign o_ready  = !r_valid || !i_q_stat.full;
    assign w_accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= n_req;
        end
    end

    assign o_req = r_req;

endmodule

`default_nettype wire

@@ sv/lru_tag_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lru_tag_back #(
    parameter int NUM_SETS = 64,
    parameter int OFF_W    = 5,
    parameter int SET_W    = 6,
    parameter int TAG_W    = 21,
    parameter int REQ_W    = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lru_tag_pkg::t_q_stat i_q_stat,
    input  logic [REQ_W-1:0]     i_q_data,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output lru_tag_pkg::t_result o_result
);
    import lru_tag_pkg::*;

    localparam int BLK_W = TAG_W + SET_W;

    logic [TAG_W-1:0]    r_tag_mem0 [NUM_SETS];
    logic [TAG_W-1:0]    r_tag_mem1 [NUM_SETS];
    logic [NUM_SETS-1:0] r_valid0;
    logic [NUM_SETS-1:0] r_valid1;
    logic [NUM_SETS-1:0] r_lru;

    t_back_state         r_state;
    t_back_state         n_state;
    logic [REQ_W-1:0]    r_req;
    logic [TAG_W-1:0]    r_rd0;
    logic [TAG_W-1:0]    r_rd1;
    logic                r_out_valid;
    t_result             r_out;
    t_result             n_out;

    logic                w_pop;
    logic                w_load;
    logic                w_out_free;
    logic [SET_W-1:0]    w_q_set;
    logic [SET_W-1:0]    w_set;
    logic [TAG_W-1:0]    w_tag;
    logic [OFF_W-1:0]    w_off;
    logic [BLK_W-1:0]    w_blk;
    logic                w_hit0;
    logic                w_hit1;
    logic                w_way;
    logic                w_miss;
    logic                w_repl;
    logic [TAG_W-1:0]    w_evict;

    logic [OFF_W+OFF_OUT_W-1:0] w_off_x;
    logic [BLK_W+BLK_OUT_W-1:0] w_blk_x;
    logic [SET_W+SET_OUT_W-1:0] w_set_x;
    logic [TAG_W+TAG_OUT_W-1:0] w_tag_x;
    logic [TAG_W+TAG_OUT_W-1:0] w_evict_x;

    assign w_q_set    = i_q_data[OFF_W +: SET_W];
    assign w_off      = r_req[OFF_W-1:0];
    assign w_set      = r_req[OFF_W +: SET_W];
    assign w_tag      = r_req[REQ_W-1 -: TAG_W];
    assign w_blk      = r_req[REQ_W-1:OFF_W];
    assign w_out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_READ:  if (!i_q_stat.empty) n_state = S_EVAL;
            S_EVAL:  if (w_out_free) n_state = S_READ;
            default: n_state = S_READ;
        endcase
    end

    always_comb begin
        w_pop  = 1'b0;
        w_load = 1'b0;
        unique case (r_state)
            S_READ:  w_pop  = !i_q_stat.empty;
            S_EVAL:  w_load = w_out_free;
            default: ;
        endcase
    end

    assign o_pop = w_pop;

    assign w_hit0 = r_valid0[w_set] && (r_rd0 == w_tag);
    assign w_hit1 = r_valid1[w_set] && (r_rd1 == w_tag);

    always_comb begin
        w_way   = 1'b0;
        w_miss  = 1'b0;
        w_repl  = 1'b0;
        w_evict = '0;
        if (w_hit0) begin
            w_way = 1'b0;
        end else if (w_hit1) begin
            w_way = 1'b1;
        end else begin
            w_miss = 1'b1;
            if (!r_valid0[w_set]) begin
                w_way = 1'b0;
            end else if (!r_valid1[w_set]) begin
                w_way = 1'b1;
            end else begin
                w_way   = r_lru[w_set];
                w_repl  = 1'b1;
                w_evict = r_lru[w_set] ? r_rd1 : r_rd0;
            end
        end
    end

    always_comb begin
        w_off_x                = '0;
        w_off_x[OFF_W-1:0]     = w_off;
        w_blk_x                = '0;
        w_blk_x[BLK_W-1:0]     = w_blk;
        w_set_x                = '0;
        w_set_x[SET_W-1:0]     = w_set;
        w_tag_x                = '0;
        w_tag_x[TAG_W-1:0]     = w_tag;
        w_evict_x              = '0;
        w_evict_x[TAG_W-1:0]   = w_evict;

        n_out.byte_offset    = w_off_x[OFF_OUT_W-1:0];
        n_out.block_number   = w_blk_x[BLK_OUT_W-1:0];
        n_out.set_index      = w_set_x[SET_OUT_W-1:0];
        n_out.way_used       = w_way;
        n_out.tag_value      = w_tag_x[TAG_OUT_W-1:0];
        n_out.is_miss        = w_miss;
        n_out.replaced_valid = w_repl;
        n_out.evicted_tag    = w_evict_x[TAG_OUT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_READ;
            r_out_valid <= 1'b0;
            r_valid0    <= '0;
            r_valid1    <= '0;
            r_lru       <= '0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid  <= 1'b1;
                r_lru[w_set] <= ~w_way;
                if (w_miss) begin
                    if (w_way) begin
                        r_valid1[w_set] <= 1'b1;
                    end else begin
                        r_valid0[w_set] <= 1'b1;
                    end
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_req <= i_q_data;
            r_rd0 <= r_tag_mem0[w_q_set];
            r_rd1 <= r_tag_mem1[w_q_set];
        end
        if (w_load && w_miss) begin
            if (w_way) begin
                r_tag_mem1[w_set] <= w_tag;
            end else begin
                r_tag_mem0[w_set] <= w_tag;
            end
        end
        if (w_load) begin
            r_out <= n_out;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

`include "two_way_lru_cache_tag_lookup_macros.svh"

    `LTL_ASSERT_NEXT(a_load_shows_result, w_load, r_out_valid, "result register not loaded")
    `LTL_ASSERT_NEXT(a_lru_points_away, w_load, r_lru[$past(w_set)] != $past(w_way), "lru not updated")
    `LTL_ASSERT_NEXT(a_fill_way0_valid, w_load && w_miss && !w_way, r_valid0[$past(w_set)], "way 0 not marked valid")
    `LTL_ASSERT_NOW(a_no_evict_no_tag, r_out_valid && !r_out.replaced_valid, r_out.evicted_tag == '0, "evicted tag without eviction")

endmodule

`default_nettype wire

@@ dv/two_way_lru_cache_tag_lookup_test.sv @@
`timescale 1ns / 1ps

module two_way_lru_cache_tag_lookup_test;
    import lru_tag_pkg::*;

    localparam int SETS         = 64;
    localparam int RANDOM_ITEMS = 1950;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int HOLD_AT      = 700;
    localparam int HOLD_CYCLES  = 300;

    typedef struct {
        logic [IN_TDATA_W-1:0] addr;
        bit                    typed;
        t_result               want;
    } t_directed_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // address
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // byte_offset, block_number, set_index, way_used, tag_value, is_miss,
    // replaced_valid, evicted_tag, zero pad
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    bit      row_typed;
    t_result row_want;

    logic [TAG_OUT_W-1:0] line_tag [0:2*SETS-1];
    bit                   line_valid [0:2*SETS-1];
    bit                   set_lru [0:SETS-1];
    logic [TAG_OUT_W-1:0] tag_pool [0:2];

    t_result       pending_lookups[$];
    t_directed_row directed_rows[$];
    int            fail_count = 0;
    int            items_sent = 0;
    int            results_taken = 0;
    int            cycle_count = 0;

    two_way_lru_cache_tag_lookup i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    function automatic t_result result_of(input logic [OFF_OUT_W-1:0] off,
                                          input logic [BLK_OUT_W-1:0] blk,
                                          input logic [SET_OUT_W-1:0] set_sel,
                                          input logic way, input logic [TAG_OUT_W-1:0] tag,
                                          input logic miss, input logic repl,
                                          input logic [TAG_OUT_W-1:0] evt);
        t_result r;
        r.byte_offset    = off;
        r.block_number   = blk;
        r.set_index      = set_sel;
        r.way_used       = way;
        r.tag_value      = tag;
        r.is_miss        = miss;
        r.replaced_valid = repl;
        r.evicted_tag    = evt;
        return r;
    endfunction

    // Split the address, look up both ways, then fill or evict and update LRU.
    function automatic t_result lookup_directory(input logic [IN_TDATA_W-1:0] addr);
        t_result r;
        int      base;
        r              = '0;
        r.byte_offset  = addr[OFF_OUT_W-1:0];
        r.block_number = addr[OFF_OUT_W +: BLK_OUT_W];
        r.set_index    = addr[OFF_OUT_W +: SET_OUT_W];
        r.tag_value    = addr[OFF_OUT_W+SET_OUT_W +: TAG_OUT_W];
        base           = 2 * r.set_index;
        if (line_valid[base] && line_tag[base] == r.tag_value) begin
            r.way_used = 1'b0;
        end else if (line_valid[base+1] && line_tag[base+1] == r.tag_value) begin
            r.way_used = 1'b1;
        end else begin
            r.is_miss = 1'b1;
            if (!line_valid[base]) begin
                r.way_used = 1'b0;
            end else if (!line_valid[base+1]) begin
                r.way_used = 1'b1;
            end else begin
                r.way_used       = set_lru[r.set_index];
                r.replaced_valid = 1'b1;
                r.evicted_tag    = line_tag[base + r.way_used];
            end
            line_tag[base + r.way_used]   = r.tag_value;
            line_valid[base + r.way_used] = 1'b1;
        end
        set_lru[r.set_index] = ~r.way_used;
        return r;
    endfunction

    // Mostly a few tags over a few sets so that hits and evictions recur.
    function automatic logic [IN_TDATA_W-1:0] pick_address();
        logic [SET_OUT_W-1:0] set_sel;
        logic [OFF_OUT_W-1:0] off;
        if ($urandom_range(0, 9) < 2)
            return $urandom();
        set_sel = ($urandom_range(0, 7) == 0) ? SET_OUT_W'(SETS - 1)
                                               : SET_OUT_W'($urandom_range(0, 5));
        off = OFF_OUT_W'($urandom_range(0, 31));
        return {tag_pool[$urandom_range(0, 2)], set_sel, off};
    endfunction

    task automatic note_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        end
    endtask

    task automatic check_result(input t_result want, input logic [OUT_TDATA_W-1:0] bits);
        t_result got;
        got = t_result'(bits[RESULT_W-1:0]);
        note_field("byte_offset", want.byte_offset, got.byte_offset);
        note_field("block_number", want.block_number, got.block_number);
        note_field("set_index", want.set_index, got.set_index);
        note_field("way_used", want.way_used, got.way_used);
        note_field("tag_value", want.tag_value, got.tag_value);
        note_field("is_miss", want.is_miss, got.is_miss);
        note_field("replaced_valid", want.replaced_valid, got.replaced_valid);
        note_field("evicted_tag", want.evicted_tag, got.evicted_tag);
        note_field("pad", '0, bits[OUT_TDATA_W-1:RESULT_W]);
    endtask

    // Offer one item; alternate blocks of 100 items with and without gaps.
    task automatic send_item(input logic [IN_TDATA_W-1:0] addr, input bit typed,
                             input t_result want);
        int gap;
        gap = ((items_sent / 100) % 2 == 1) ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= addr;
        row_typed     <= typed;
        row_want      <= want;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("two_way_lru_cache_tag_lookup: mismatch");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_result predicted;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_lookups.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected item %0h", $time, m_axis_tdata);
            end else begin
                check_result(pending_lookups.pop_front(), m_axis_tdata);
            end
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            predicted = lookup_directory(s_axis_tdata);
            pending_lookups.push_back(row_typed ? row_want : predicted);
        end
    end

    // Receiver: random stalls, a calm block every other 64 items, one long hold.
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            gap = ((results_taken / 64) % 2 == 1) ? 0 : $urandom_range(0, 17);
            if (results_taken == HOLD_AT) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            results_taken++;
            @(negedge i_clk);
        end
    end

    initial begin
        t_directed_row row;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        row_typed     = 1'b0;
        row_want      = '0;
        for (int k = 0; k < 2 * SETS; k++) begin
            line_tag[k]   = '0;
            line_valid[k] = 1'b0;
        end
        for (int k = 0; k < SETS; k++)
            set_lru[k] = 1'b0;
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        tag_pool[2] = TAG_OUT_W'($urandom());

        // set 0: fill way 0, hit, fill way 1, hit way 1, then evictions
        directed_rows.push_back('{32'h0000_0000, 1'b1,
                                  result_of(0, 0, 0, 0, 0, 1, 0, 0)});
        directed_rows.push_back('{32'h0000_001F, 1'b1,
                                  result_of(31, 0, 0, 0, 0, 0, 0, 0)});
        directed_rows.push_back('{32'h0000_0800, 1'b1,
                                  result_of(0, 27'h40, 0, 1, 1, 1, 0, 0)});
        directed_rows.push_back('{32'h0000_0805, 1'b1,
                                  result_of(5, 27'h40, 0, 1, 1, 0, 0, 0)});
        directed_rows.push_back('{32'h0000_1000, 1'b0, '0});
        directed_rows.push_back('{32'h0000_1800, 1'b0, '0});
        directed_rows.push_back('{32'h0000_1000, 1'b0, '0});
        directed_rows.push_back('{32'h0000_0000, 1'b0, '0});
        // set 63: all-ones tag, half tag, then evict the all-ones tag
        directed_rows.push_back('{32'hFFFF_FFFF, 1'b1,
                                  result_of(31, '1, 63, 0, '1, 1, 0, 0)});
        directed_rows.push_back('{32'hFFFF_FFE0, 1'b1,
                                  result_of(0, '1, 63, 0, '1, 0, 0, 0)});
        directed_rows.push_back('{32'h7FFF_FFFF, 1'b1,
                                  result_of(31, 27'h3FF_FFFF, 63, 1, 21'h0F_FFFF, 1, 0, 0)});
        directed_rows.push_back('{32'h0000_07E0, 1'b1,
                                  result_of(0, 27'h3F, 63, 0, 0, 1, 1, '1)});
        directed_rows.push_back('{32'hFFFF_FFFF, 1'b0, '0});
        directed_rows.push_back('{32'h7FFF_FFE0, 1'b0, '0});
        directed_rows.push_back('{32'h0000_07FF, 1'b0, '0});
        directed_rows.push_back('{32'hAAAA_AAAA, 1'b0, '0});
        directed_rows.push_back('{32'h5555_5555, 1'b0, '0});
        directed_rows.push_back('{32'hAAAA_AAA0, 1'b0, '0});
        directed_rows.push_back('{32'h8000_0000, 1'b0, '0});
        directed_rows.push_back('{32'h0000_0020, 1'b0, '0});

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            send_item(row.addr, row.typed, row.want);
        end
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 300 == 299)
                tag_pool[$urandom_range(0, 2)] = TAG_OUT_W'($urandom());
            send_item(pick_address(), 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;

        while (pending_lookups.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("two_way_lru_cache_tag_lookup: match");
        else
            $display("two_way_lru_cache_tag_lookup: mismatch");
        $finish;
    end

endmodule
